FILE: sv/ukg_pkg.sv
// Shared types, widths and codes for the union-find grouping engine.
// No dependencies; every other file refers to this package by scoped names.
package ukg_pkg;

  localparam int MAX_NODES = 8192;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int WEIGHT_W  = 31;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_LIMIT = 1'b1;

  // Command codes of an input word.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // Job kinds decided by the front end.
  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_EDGE  = 2'd1;
  localparam logic [1:0] K_SKIP  = 2'd2;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_t;

  typedef struct packed {
    logic                joined;
    logic [CNT_W-1:0]    groups_left;
    logic                limit_reached;
    logic [WEIGHT_W-1:0] reported_weight;
  } out_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_weight;
  } job_t;

  // Node count in use: zero counts as one, anything above the table size is clamped.
  function automatic logic [CNT_W-1:0] nodes_in_use(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) r = CNT_W'(1);
    if (n > CNT_W'(MAX_NODES)) r = CNT_W'(MAX_NODES);
    return r;
  endfunction

endpackage

FILE: sv/ukg_front.sv
// Front end: classifies each input word into a job for the back end.
// Depends on ukg_pkg.
module ukg_front (
  input  ukg_pkg::in_t              word,
  input  logic [ukg_pkg::CNT_W-1:0] node_count,
  output ukg_pkg::job_t             job
);

  logic [ukg_pkg::CNT_W-1:0] n_use;
  logic                      in_range;

  always_comb begin
    n_use    = ukg_pkg::nodes_in_use(node_count);
    in_range = ({1'b0, word.node_a} < n_use) && ({1'b0, word.node_b} < n_use);
    job.node_a      = word.node_a;
    job.node_b      = word.node_b;
    job.edge_weight = word.edge_weight;
    if (word.command == ukg_pkg::CMD_START) begin
      job.kind = ukg_pkg::K_START;
    end else if (in_range) begin
      job.kind = ukg_pkg::K_EDGE;
    end else begin
      job.kind = ukg_pkg::K_SKIP;
    end
  end

endmodule

FILE: sv/ukg_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on ukg_pkg.
module ukg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ukg_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output ukg_pkg::job_t head
);

  ukg_pkg::job_t slots [0:1];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: sv/ukg_back.sv
// Back end: disjoint-set forest in two memories, root walks with path
// compression, union by size, group count and limit check. Depends on ukg_pkg.
module ukg_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  ukg_pkg::job_t             q_head,
  output logic                      q_pop,
  input  logic [ukg_pkg::CNT_W-1:0] node_count,
  input  logic [ukg_pkg::CNT_W-1:0] group_limit,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ukg_pkg::out_t             out_data
);

  localparam int NW = ukg_pkg::NODE_W;
  localparam int CW = ukg_pkg::CNT_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FA   = 4'd2;
  localparam logic [3:0] S_CA   = 4'd3;
  localparam logic [3:0] S_FB   = 4'd4;
  localparam logic [3:0] S_CB   = 4'd5;
  localparam logic [3:0] S_SZA  = 4'd6;
  localparam logic [3:0] S_SZB  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [NW-1:0] par [0:ukg_pkg::MAX_NODES-1];
  logic [CW-1:0] siz [0:ukg_pkg::MAX_NODES-1];

  logic [NW-1:0] par_q;
  logic [CW-1:0] siz_q;
  logic [NW-1:0] par_ra;
  logic [NW-1:0] siz_ra;
  logic          par_we;
  logic [NW-1:0] par_wa;
  logic [NW-1:0] par_wd;
  logic          siz_we;
  logic [NW-1:0] siz_wa;
  logic [CW-1:0] siz_wd;

  logic [3:0]                  st;
  logic [NW-1:0]               idx;
  logic [NW-1:0]               x;
  logic [NW-1:0]               ra;
  logic [NW-1:0]               rb;
  logic [CW-1:0]               sa;
  logic [NW-1:0]               a_r;
  logic [NW-1:0]               b_r;
  logic [ukg_pkg::WEIGHT_W-1:0] w_r;
  logic                        jn;
  logic [CW-1:0]               cnt;
  logic                        fin;
  logic                        ov;
  ukg_pkg::out_t               res;

  logic          slot_free;
  logic          res_load;
  logic          hit;
  logic [CW-1:0] n_use;
  logic          a_small;

  assign out_valid = ov;
  assign out_data  = res;

  always_comb begin
    slot_free = !ov || !out_stall;
    n_use     = ukg_pkg::nodes_in_use(node_count);
    hit       = !fin && (cnt < group_limit);
    a_small   = sa < siz_q;
    q_pop     = 1'b0;
    res_load  = 1'b0;
    par_ra    = x;
    siz_ra    = ra;
    par_we    = 1'b0;
    par_wa    = x;
    par_wd    = ra;
    siz_we    = 1'b0;
    siz_wa    = ra;
    siz_wd    = sa + siz_q;
    case (st)
      S_CLR: begin
        par_we = 1'b1;
        par_wa = idx;
        par_wd = idx;
        siz_we = 1'b1;
        siz_wa = idx;
        siz_wd = CW'(1);
      end
      S_IDLE: begin
        par_ra = q_head.node_a;
        if (!q_empty) begin
          q_pop    = (q_head.kind != ukg_pkg::K_START) || slot_free;
          res_load = (q_head.kind == ukg_pkg::K_START) && slot_free;
        end
      end
      S_FA: begin
        par_ra = (par_q == x) ? a_r : par_q;
      end
      S_CA: begin
        if (x == ra) begin
          par_ra = b_r;
        end else begin
          par_we = 1'b1;
          par_wd = ra;
          par_ra = par_q;
        end
      end
      S_FB: begin
        par_ra = (par_q == x) ? b_r : par_q;
      end
      S_CB: begin
        if (x != rb) begin
          par_we = 1'b1;
          par_wd = rb;
          par_ra = par_q;
        end
      end
      S_SZA: begin
        siz_ra = rb;
      end
      S_SZB: begin
        // Smaller tree goes under the larger; ties keep the first root on top.
        siz_we = 1'b1;
        siz_wa = a_small ? rb : ra;
        par_we = 1'b1;
        par_wa = a_small ? ra : rb;
        par_wd = a_small ? rb : ra;
      end
      S_DONE: begin
        res_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) par[par_wa] <= par_wd;
    par_q <= par[par_ra];
  end

  always_ff @(posedge clk) begin
    if (siz_we) siz[siz_wa] <= siz_wd;
    siz_q <= siz[siz_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_CLR;
      idx <= '0;
      cnt <= CW'(ukg_pkg::MAX_NODES);
      fin <= 1'b0;
      ov  <= 1'b0;
    end else begin
      if (res_load) begin
        ov <= 1'b1;
      end else if (!out_stall) begin
        ov <= 1'b0;
      end
      case (st)
        S_CLR: begin
          idx <= idx + NW'(1);
          if (idx == NW'(ukg_pkg::MAX_NODES - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            a_r <= q_head.node_a;
            b_r <= q_head.node_b;
            w_r <= q_head.edge_weight;
            x   <= q_head.node_a;
            jn  <= 1'b0;
            if (q_head.kind == ukg_pkg::K_START) begin
              cnt <= n_use;
              fin <= 1'b0;
              res <= '{joined: 1'b0, groups_left: n_use, limit_reached: 1'b0,
                       reported_weight: '0};
              idx <= '0;
              st  <= S_CLR;
            end else if (q_head.kind == ukg_pkg::K_EDGE && !fin) begin
              st <= S_FA;
            end else begin
              st <= S_DONE;
            end
          end
        end
        S_FA: begin
          if (par_q == x) begin
            ra <= x;
            x  <= a_r;
            st <= S_CA;
          end else begin
            x <= par_q;
          end
        end
        S_CA: begin
          if (x == ra) begin
            x  <= b_r;
            st <= S_FB;
          end else begin
            x <= par_q;
          end
        end
        S_FB: begin
          if (par_q == x) begin
            rb <= x;
            x  <= b_r;
            st <= S_CB;
          end else begin
            x <= par_q;
          end
        end
        S_CB: begin
          if (x == rb) begin
            st <= (ra == rb) ? S_DONE : S_SZA;
          end else begin
            x <= par_q;
          end
        end
        S_SZA: begin
          sa <= siz_q;
          st <= S_SZB;
        end
        S_SZB: begin
          if (cnt != '0) cnt <= cnt - CW'(1);
          jn <= 1'b1;
          st <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            res <= '{joined: jn, groups_left: cnt, limit_reached: hit,
                     reported_weight: hit ? w_r : '0};
            if (hit) fin <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/union_find_kruskal_grouping.sv
// Top level of the union-find grouping engine: configuration registers,
// front end, job queue and back end. Depends on ukg_pkg, ukg_front, ukg_queue, ukg_back.
//
//   channel   direction  handshake            word
//   in        input      in_valid / in_stall  ukg_pkg::in_t  (command, nodes, weight)
//   out       output     out_valid/out_stall  ukg_pkg::out_t (joined, count, report)
//   cfg       input      cfg_write            cfg_index, cfg_data (no read-back)
//
// An edge word walks from each endpoint to its root and then along the same path again to
// compress it, through the single read port of the parent memory, then reads both sizes
// and links the roots unless they already share one; an edge out of range or after the
// report skips the walks. A word waits in the queue until the back end takes it, and
// union by size keeps depths near log2 of the node count.
// A start word, and reset itself, clear all 8192 entries of both memories before the
// back end takes the next word; configuration writes are taken throughout.
// A two-word queue lets input words be taken while the back end works, and the
// output register lets the back end finish its next word while a result is stalled.
module union_find_kruskal_grouping (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ukg_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ukg_pkg::out_t                 out_data,
  input  logic                          cfg_write,
  input  logic [ukg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ukg_pkg::CNT_W-1:0]     cfg_data
);

  // Configuration registers; node_count is read live by the front and back ends, group_limit by the back end.
  logic [ukg_pkg::CNT_W-1:0] node_count;
  logic [ukg_pkg::CNT_W-1:0] group_limit;

  ukg_pkg::job_t job;
  ukg_pkg::job_t head;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          push;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= ukg_pkg::CNT_W'(ukg_pkg::MAX_NODES);
      group_limit <= ukg_pkg::CNT_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        ukg_pkg::REG_NODE_COUNT:  node_count  <= cfg_data;
        ukg_pkg::REG_GROUP_LIMIT: group_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A word is taken whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  ukg_front u_front (
    .word       (in_data),
    .node_count (node_count),
    .job        (job)
  );

  ukg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  ukg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .node_count  (node_count),
    .group_limit (group_limit),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
